FILE: rtl/mmrn_pkg.sv
// Package for the min/max range normalizer: field widths, payload structs,
// sequencer states and the divider request type. No dependencies.
`timescale 1ns / 1ps

package mmrn_pkg;

    localparam int DATA_W          = 32;
    localparam int SPAN_W          = 13;
    localparam int HALF_W          = SPAN_W - 1;
    localparam int FRAC_W          = 16;
    localparam int PROD_W          = DATA_W + SPAN_W;
    localparam int MAX_SAMPLES_DEF = 64;

    localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(256);

    // Divider: 64-bit dividend, 32-bit divisor, 32 quotient bits
    localparam int DIV_N_W = 2 * DATA_W;
    localparam int DIV_D_W = DATA_W;
    localparam int DIV_Q_W = DATA_W;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_value;
        logic                     is_last_sample;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] scaled_value;
        logic        [DATA_W-1:0] scale_factor;
        logic signed [DATA_W-1:0] offset_value;
        logic                     is_last_result;
    } out_item_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SCALE,
        ST_SCALE_WAIT,
        ST_OFFSET,
        ST_OFFSET_ADD,
        ST_READ,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_EMIT
    } state_t;

endpackage

FILE: rtl/min_max_range_normalizer.sv
// Min/max range normalizer. Load: one sample per cycle into the sample RAM.
// Closing: scale = dist/span and the offset, then per result a RAM read, a
// multiply, a bit-serial divide on the shared one-bit-per-cycle divider and
// an output load; a flat set skips the divide. A stall at the output
// register holds the emit step until the previous result is taken.
// Reset (rst_n, async, active low): empty set, span 256, no result pending.
`timescale 1ns / 1ps

module min_max_range_normalizer
    import mmrn_pkg::*;
#(
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_ready,
    input  in_item_t  sample_data,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result_data,
    input  logic              span_we,
    input  logic [SPAN_W-1:0] span_wdata
);

    localparam int AW    = $clog2(MAX_SAMPLES);
    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                   state_reg;
    state_t                   state_next;
    logic [CNT_W-1:0]         count_reg;   // samples stored in current set
    logic [CNT_W-1:0]         idx_reg;     // emit pointer
    logic signed [DATA_W-1:0] min_reg;
    logic signed [DATA_W-1:0] max_reg;
    logic [SPAN_W-1:0]        span_reg;
    logic [DATA_W-1:0]        dist_reg;
    logic [DATA_W-1:0]        scale_reg;
    logic [DATA_W-1:0]        off_mul_reg;
    logic signed [DATA_W-1:0] offset_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic signed [DATA_W-1:0] res_value_reg;
    logic                     out_valid_reg;
    out_item_t                out_data_reg;

    // ------------------------------------------------------------------
    // Derived values
    // ------------------------------------------------------------------
    logic [SPAN_W-1:0]   hi_w;
    logic [HALF_W-1:0]   half_w;
    logic [DATA_W-1:0]   dist_w;
    logic [DATA_W-1:0]   diff_w;
    logic [PROD_W-1:0]   prod_w;
    logic [DATA_W+HALF_W-1:0] off_mul_w;
    logic                in_xfer;
    logic                store_ok;
    logic                out_free;
    logic                last_res;
    logic                flat;

    logic [DATA_W-1:0]   ram_rdata;
    logic                ram_re;
    div_req_t            div_req;
    logic [DIV_Q_W-1:0]  div_quotient;
    logic                div_done;

    // Decoded strobes
    logic ld_scale;
    logic ld_off_mul;
    logic ld_offset;
    logic ld_prod;
    logic ld_flat;
    logic ld_res;
    logic ld_out;

    always_comb
    begin
        // a span of zero behaves as one
        hi_w      = (span_reg == '0) ? SPAN_W'(1) : span_reg;
        half_w    = hi_w[SPAN_W-1:1];
        // max >= min, so the wrapped 32-bit difference is the exact distance
        dist_w    = DATA_W'(max_reg - min_reg);
        diff_w    = DATA_W'(signed'(ram_rdata) - min_reg);
        prod_w    = PROD_W'(diff_w) * PROD_W'(hi_w);
        off_mul_w = (DATA_W + HALF_W)'(half_w) * (DATA_W + HALF_W)'(scale_reg);
        in_xfer   = sample_valid && sample_ready;
        store_ok  = (count_reg < CNT_W'(MAX_SAMPLES));
        out_free  = !out_valid_reg || result_ready;
        last_res  = (CNT_W'(idx_reg + 1'b1) == count_reg);
        flat      = (dist_reg == '0);
    end

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer && sample_data.is_last_sample)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:      state_next = ST_SCALE_WAIT;
            ST_SCALE_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_OFFSET;
                end
            end
            ST_OFFSET:     state_next = ST_OFFSET_ADD;
            ST_OFFSET_ADD: state_next = ST_READ;
            ST_READ:       state_next = ST_MUL;
            ST_MUL:        state_next = flat ? ST_EMIT : ST_DIV_START;
            ST_DIV_START:  state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = last_res ? ST_LOAD : ST_READ;
                end
            end
            default:       state_next = ST_LOAD;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs and strobes
    // ------------------------------------------------------------------
    always_comb
    begin
        sample_ready     = 1'b0;
        ram_re           = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {(DIV_N_W - DATA_W)'(0), dist_w};
        div_req.divisor  = DIV_D_W'(hi_w);
        ld_scale         = 1'b0;
        ld_off_mul       = 1'b0;
        ld_offset        = 1'b0;
        ld_prod          = 1'b0;
        ld_flat          = 1'b0;
        ld_res           = 1'b0;
        ld_out           = 1'b0;
        case (state_reg)
            ST_LOAD:       sample_ready = 1'b1;
            ST_SCALE:      div_req.start = 1'b1;   // dist / span
            ST_SCALE_WAIT: ld_scale = div_done;
            ST_OFFSET:     ld_off_mul = 1'b1;
            ST_OFFSET_ADD: ld_offset = 1'b1;
            ST_READ:       ram_re = 1'b1;
            ST_MUL:
            begin
                ld_prod = !flat;
                ld_flat = flat;
            end
            ST_DIV_START:
            begin
                // (diff * span) << 16 over dist
                div_req.start    = 1'b1;
                div_req.dividend = DIV_N_W'({prod_reg, FRAC_W'(0)});
                div_req.divisor  = dist_reg;
            end
            ST_DIV_WAIT:   ld_res = div_done;
            ST_EMIT:       ld_out = out_free;
            default:       sample_ready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            idx_reg       <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            span_reg      <= SPAN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (span_we)
            begin
                span_reg <= span_wdata;
            end

            // samples past a full store are dropped; the last flag still closes
            if (in_xfer && store_ok)
            begin
                count_reg <= count_reg + 1'b1;
                if (count_reg == '0)
                begin
                    min_reg <= sample_data.sample_value;
                    max_reg <= sample_data.sample_value;
                end
                else
                begin
                    if (sample_data.sample_value < min_reg)
                    begin
                        min_reg <= sample_data.sample_value;
                    end
                    if (sample_data.sample_value > max_reg)
                    begin
                        max_reg <= sample_data.sample_value;
                    end
                end
            end

            if (ld_out)
            begin
                out_valid_reg <= 1'b1;
                if (last_res)
                begin
                    idx_reg   <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCALE)
        begin
            dist_reg <= dist_w;
        end
        if (ld_scale)
        begin
            scale_reg <= div_quotient;
        end
        if (ld_off_mul)
        begin
            off_mul_reg <= off_mul_w[DATA_W-1:0];
        end
        if (ld_offset)
        begin
            offset_reg <= signed'(DATA_W'(off_mul_reg + unsigned'(min_reg)));
        end
        if (ld_prod)
        begin
            prod_reg <= prod_w;
        end
        if (ld_flat)
        begin
            // all samples equal: pass through
            res_value_reg <= signed'(ram_rdata);
        end
        else if (ld_res)
        begin
            res_value_reg <= signed'(DATA_W'(div_quotient
                                     - DATA_W'({half_w, FRAC_W'(0)})));
        end
        if (ld_out)
        begin
            out_data_reg.scaled_value   <= res_value_reg;
            out_data_reg.scale_factor   <= scale_reg;
            out_data_reg.offset_value   <= offset_reg;
            out_data_reg.is_last_result <= last_res;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Sample store. Writes only in ST_LOAD, reads only during the emit
    // pass, so the two ports never touch the same entry in one cycle.
    // ------------------------------------------------------------------
    mmrn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_SAMPLES)
    ) u_store (
        .clk   (clk),
        .we    (in_xfer && store_ok),
        .waddr (count_reg[AW-1:0]),
        .wdata (unsigned'(sample_data.sample_value)),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // Shared divider: scale once per set, then one quotient per sample unless the set is flat
    mmrn_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .quotient (div_quotient),
        .done     (div_done)
    );

endmodule

FILE: rtl/mmrn_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module mmrn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mmrn_divider.sv
// Restoring divider, one quotient bit per cycle, 32 iterations.
// Depends on mmrn_pkg. Caller guarantees dividend[63:32] < divisor.
`timescale 1ns / 1ps

module mmrn_divider
    import mmrn_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  div_req_t           req,
    output logic [DIV_Q_W-1:0] quotient,
    output logic               done
);

    localparam int CNT_W = $clog2(DIV_Q_W);

    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] rem_next;
    logic [DIV_D_W-1:0] dvd_reg;
    logic [DIV_D_W-1:0] divisor_reg;
    logic [DIV_Q_W-1:0] quo_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;
    logic [DIV_D_W:0]   trial;
    logic               ge;

    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DIV_D_W-1]};
        ge       = (trial >= {1'b0, divisor_reg});
        rem_next = ge ? DIV_D_W'(trial - {1'b0, divisor_reg}) : trial[DIV_D_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_Q_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg     <= req.dividend[DIV_N_W-1:DIV_D_W];
            dvd_reg     <= req.dividend[DIV_D_W-1:0];
            divisor_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[DIV_D_W-2:0], 1'b0};
            quo_reg <= {quo_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

FILE: rtl/mmrn_checker.sv
// Port-level checker for the min/max range normalizer, bound to the top level.
// Depends on mmrn_pkg and min_max_range_normalizer.
`timescale 1ns / 1ps

module mmrn_checker
    import mmrn_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              sample_valid,
    input logic              sample_ready,
    input in_item_t          sample_data,
    input logic              result_valid,
    input logic              result_ready,
    input out_item_t         result_data,
    input logic              span_we,
    input logic [SPAN_W-1:0] span_wdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed or dropped while stalled");

    // closing sample ends the load window
    a_close_stops_load: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && sample_data.is_last_sample |=> !sample_ready)
        else $error("input still open after closing sample");

    // plain sample keeps the load window open
    a_load_open: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && sample_ready && !sample_data.is_last_sample |=> sample_ready)
        else $error("input closed without a last flag");

    // a mid-set result appears only while input is held off
    a_emit_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) && !result_data.is_last_result |-> !sample_ready)
        else $error("input open during emit pass");

endmodule

bind min_max_range_normalizer mmrn_checker u_checker (.*);
